[hdl/bni_pkg.sv]
// Shared types, constants and the round-and-saturate helper for the batch-norm block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bni_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS     = 8;
  localparam int MAX_SLOTS_DEF = 256;
  localparam int SLOT_W        = 8;
  localparam int REP_CNT_W     = 20;
  localparam int PIU_W         = 9;
  localparam int REP_W         = 21;
  localparam int CFG_W         = 21;
  localparam int CFG_IDX_W     = 1;
  // wide enough for the result accumulator plus the rounding offset
  localparam int RS_W          = 2 * DATA_W + 4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARAMS_IN_USE = 1'b0,
    CFG_REPEAT_COUNT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                     operation;
    logic [SLOT_W-1:0]        param_index;
    logic signed [DATA_W-1:0] mean_value;
    logic signed [DATA_W-1:0] recip_sqrt_var_value;
    logic signed [DATA_W-1:0] gamma_value;
    logic signed [DATA_W-1:0] beta_value;
    logic signed [DATA_W-1:0] sample;
    logic                     restart;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
    logic [SLOT_W-1:0]        slot_used;
  } out_item_t;

  // sample with its slot parameters, after the table read
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] mean;
    logic signed [DATA_W-1:0] scale;
    logic signed [DATA_W-1:0] beta;
  } stage_t;

  localparam logic signed [RS_W-1:0] RS_HALF = RS_W'(2 ** FRAC_BITS / 2);
  localparam logic signed [RS_W-1:0] RS_MAX  = RS_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [RS_W-1:0] RS_MIN  = -RS_MAX - RS_W'(1);

  // Round half up to FRAC_BITS fewer fraction bits, then clip.
  // Returns {clipped, value}.
  function automatic logic [DATA_W:0] round_sat(input logic signed [RS_W-1:0] v);
    logic signed [RS_W-1:0] r;
    logic [DATA_W:0]        res;
    r = (v + RS_HALF) >>> FRAC_BITS;
    if (r > RS_MAX) begin
      res = {1'b1, RS_MAX[DATA_W-1:0]};
    end else if (r < RS_MIN) begin
      res = {1'b1, RS_MIN[DATA_W-1:0]};
    end else begin
      res = {1'b0, r[DATA_W-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/bni_ctrl.sv]
// Configuration registers and the repeat/slot position counters.
// Depends on bni_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bni_ctrl
  import bni_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 take,
  input  wire logic                 restart,
  output logic      [SLOT_W-1:0]    slot
);

  localparam int LIM_W = ($clog2(MAX_SLOTS + 1) > PIU_W) ? $clog2(MAX_SLOTS + 1) : PIU_W;
  localparam logic [LIM_W-1:0] SLOT_LIMIT = LIM_W'(MAX_SLOTS);
  localparam logic [REP_W-1:0] REP_LIMIT  = REP_W'(2 ** REP_CNT_W);

  logic [PIU_W-1:0]     piu_r;
  logic [REP_W-1:0]     rep_r;
  logic [REP_CNT_W-1:0] rc_r, rc_nxt, rc_base;
  logic [SLOT_W-1:0]    sc_r, sc_nxt, sc_base;
  logic [REP_W-1:0]     reps_eff, rc_sum;
  logic [LIM_W-1:0]     slots_eff, sc_sum, piu_ext;

  always_comb begin
    rc_base = restart ? '0 : rc_r;
    sc_base = restart ? '0 : sc_r;

    if (rep_r == '0) begin
      reps_eff = REP_W'(1);
    end else if (rep_r > REP_LIMIT) begin
      reps_eff = REP_LIMIT;
    end else begin
      reps_eff = rep_r;
    end

    piu_ext = LIM_W'(piu_r);
    if (piu_ext == '0) begin
      slots_eff = LIM_W'(1);
    end else if (piu_ext > SLOT_LIMIT) begin
      slots_eff = SLOT_LIMIT;
    end else begin
      slots_eff = piu_ext;
    end

    // one extra bit catches the counter wrap as well as the limit
    rc_sum = REP_W'(rc_base) + REP_W'(1);
    sc_sum = LIM_W'(sc_base) + LIM_W'(1);
    rc_nxt = rc_sum[REP_CNT_W-1:0];
    sc_nxt = sc_base;
    if (rc_sum >= reps_eff) begin
      rc_nxt = '0;
      sc_nxt = (sc_sum >= slots_eff) ? '0 : sc_sum[SLOT_W-1:0];
    end

    slot = (LIM_W'(sc_base) >= SLOT_LIMIT) ? '0 : sc_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= PIU_W'(1);
      rep_r <= REP_W'(1);
      rc_r  <= '0;
      sc_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PARAMS_IN_USE: piu_r <= cfg_wdata[PIU_W-1:0];
          CFG_REPEAT_COUNT:  rep_r <= cfg_wdata[REP_W-1:0];
        endcase
      end
      if (take) begin
        rc_r <= rc_nxt;
        sc_r <= sc_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bni_param_store.sv]
// Input register, scale product for loads, and the three parameter tables.
// Depends on bni_pkg; feeds bni_datapath with samples and their slot parameters.
`timescale 1ns / 1ps
`default_nettype none

module bni_param_store
  import bni_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire in_item_t          in_data,
  input  wire logic [SLOT_W-1:0] slot,
  output logic                   in_stall,
  output logic                   accept,
  input  wire logic              dp_ready,
  output logic                   s2_valid,
  output stage_t                 s2_data
);

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IDX_W  = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;

  logic [DATA_W-1:0] mean_mem  [MAX_SLOTS];
  logic [DATA_W-1:0] scale_mem [MAX_SLOTS];
  logic [DATA_W-1:0] beta_mem  [MAX_SLOTS];

  logic                     s1_v_r;
  in_item_t                 s1_item_r;
  logic [SLOT_W-1:0]        s1_slot_r;
  logic                     s2_v_r;
  stage_t                   s2_r;

  logic                     s1_adv, s2_adv, wr_en, rd_en, idx_ok;
  logic [IDX_W-1:0]         wr_idx, rd_idx;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [2*DATA_W-1:0] scale_prod;
  logic [DATA_W:0]          scale_rs;

  always_comb begin
    s2_adv   = !s2_v_r || dp_ready;
    s1_adv   = !s1_v_r || s2_adv;
    in_stall = !s1_adv;
    accept   = in_valid && s1_adv;

    wr_idx  = IDX_W'(s1_item_r.param_index);
    rd_idx  = IDX_W'(s1_slot_r);
    wr_addr = wr_idx[ADDR_W-1:0];
    rd_addr = rd_idx[ADDR_W-1:0];
    idx_ok  = 32'(s1_item_r.param_index) < MAX_SLOTS;

    // write the load as it leaves the input register; reads happen on the same edges
    wr_en = s1_v_r && (s1_item_r.operation == OP_LOAD) && s2_adv && idx_ok;
    rd_en = s1_v_r && (s1_item_r.operation == OP_SAMPLE) && s2_adv;

    scale_prod = s1_item_r.recip_sqrt_var_value * s1_item_r.gamma_value;
    scale_rs   = round_sat(RS_W'(scale_prod));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r && (s1_item_r.operation == OP_SAMPLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
      s1_slot_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mean_mem[wr_addr]  <= s1_item_r.mean_value;
      scale_mem[wr_addr] <= scale_rs[DATA_W-1:0];
      beta_mem[wr_addr]  <= s1_item_r.beta_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s2_r.mean   <= mean_mem[rd_addr];
      s2_r.scale  <= scale_mem[rd_addr];
      s2_r.beta   <= beta_mem[rd_addr];
      s2_r.sample <= s1_item_r.sample;
      s2_r.slot   <= s1_slot_r;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2_data  = s2_r;

endmodule

`default_nettype wire

[hdl/bni_datapath.sv]
// Subtract, multiply and round/saturate stages with the output register.
// Depends on bni_pkg; fed by bni_param_store.
`timescale 1ns / 1ps
`default_nettype none

module bni_datapath
  import bni_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  output logic        ready,
  input  wire logic   out_stall,
  output logic        out_valid,
  output out_item_t   out_data
);

  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + DATA_W;

  logic                     s3_v_r, s4_v_r, out_v_r;
  logic signed [DIFF_W-1:0] s3_diff_r;
  logic signed [DATA_W-1:0] s3_scale_r, s3_beta_r, s4_beta_r;
  logic [SLOT_W-1:0]        s3_slot_r, s4_slot_r;
  logic signed [PROD_W-1:0] s4_prod_r;
  out_item_t                out_r;

  logic                     out_rdy, s4_adv, s3_adv;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [RS_W-1:0]   acc;
  logic [DATA_W:0]          res;

  always_comb begin
    out_rdy = !out_v_r || !out_stall;
    s4_adv  = !s4_v_r || out_rdy;
    s3_adv  = !s3_v_r || s4_adv;
    ready   = s3_adv;

    diff = DIFF_W'(in_data.sample) - DIFF_W'(in_data.mean);
    prod = PROD_W'(s3_diff_r) * PROD_W'(s3_scale_r);
    acc  = RS_W'(s4_prod_r) + (RS_W'(s4_beta_r) <<< FRAC_BITS);
    res  = round_sat(acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s3_adv) s3_v_r <= in_valid;
      if (s4_adv) s4_v_r <= s3_v_r;
      if (out_rdy) out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && in_valid) begin
      s3_diff_r  <= diff;
      s3_scale_r <= in_data.scale;
      s3_beta_r  <= in_data.beta;
      s3_slot_r  <= in_data.slot;
    end
    if (s4_adv && s3_v_r) begin
      s4_prod_r <= prod;
      s4_beta_r <= s3_beta_r;
      s4_slot_r <= s3_slot_r;
    end
    if (out_rdy && s4_v_r) begin
      out_r.result_value <= res[DATA_W-1:0];
      out_r.saturated    <= res[DATA_W];
      out_r.slot_used    <= s4_slot_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[hdl/batch_norm_inference.sv]
// Batch-norm inference block: y = (x - mean) * scale + beta in signed Q8.8.
// Input channel carries loads and samples; one result per sample.
// Load transactions write one parameter slot (mean, beta, saturated scale product).
// Sample transactions take their slot from the repeat and slot counters; restart on a
// sample clears both counters before use. Loads produce no result.
// Configuration: params_in_use (index 0) and repeat_count (index 1), written while idle.
// Throughput: one transaction per cycle, sustained while out_stall is low, limited by the
// single table port set that serves one load write or one sample read per cycle.
// Pipeline: an accepted sample passes the input register, table read, subtract, multiply
// and round/saturate into the output register.
// A load is visible to a sample accepted in the very next cycle.
// Stall: out_stall holds the result register; the pipe behind it keeps filling empty
// stages, and in_stall rises only when every stage holds a transaction.
// Reset: synchronous, clears valids and counters, sets both registers to 1;
// table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module batch_norm_inference
  import bni_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic              accept, take, dp_ready, s2_valid;
  logic [SLOT_W-1:0] slot;
  stage_t            s2_data;

  assign take = accept && (in_data.operation == OP_SAMPLE);

  bni_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .restart   (in_data.restart),
    .slot      (slot)
  );

  bni_param_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .slot     (slot),
    .in_stall (in_stall),
    .accept   (accept),
    .dp_ready (dp_ready),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  bni_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .ready     (dp_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/bni_checker.sv]
// Port-level checks for batch_norm_inference, attached by bind.
// Depends on bni_pkg and the top-level port names.
`timescale 1ns / 1ps
`default_nettype none

module bni_checker
  import bni_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only when the whole pipe is full behind a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipe");

  // a clipped result sits at one of the range limits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.result_value == RS_MAX[DATA_W-1:0]) ||
      (out_data.result_value == RS_MIN[DATA_W-1:0]))
    else $error("saturated result not at a limit");

endmodule

bind batch_norm_inference bni_checker u_bni_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for batch_norm_inference: a scoreboard predicts each result from the
// parameter loads and sample transactions and checks every output transaction against it.
// Depends on bni_pkg and the batch_norm_inference RTL only.
`timescale 1ns / 1ps

module tb_top;
  import bni_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_SLOTS    = MAX_SLOTS_DEF;
  localparam int IDLE_PCT     = 33;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  batch_norm_inference i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // scoreboard state
  in_item_t                 pending_items[$];
  out_item_t                expected_results[$];
  logic signed [DATA_W-1:0] mean_mem  [NUM_SLOTS];
  logic signed [DATA_W-1:0] scale_mem [NUM_SLOTS];
  logic signed [DATA_W-1:0] beta_mem  [NUM_SLOTS];
  logic [REP_CNT_W-1:0]     rep_pos   = '0;
  logic [SLOT_W-1:0]        slot_pos  = '0;
  logic [PIU_W-1:0]         slots_reg = 9'd1;
  logic [REP_W-1:0]         reps_reg  = 21'd1;
  int                       idle_pct  = IDLE_PCT;
  int                       mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // round half up by FRAC_BITS, clip to DATA_W signed; returns {clipped, value}
  function automatic logic [DATA_W:0] round_clip(input longint v);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (DATA_W - 1)) - 1;
    lo = -hi - 1;
    r  = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > hi) begin
      return {1'b1, hi[DATA_W-1:0]};
    end else if (r < lo) begin
      return {1'b1, lo[DATA_W-1:0]};
    end
    return {1'b0, r[DATA_W-1:0]};
  endfunction

  // update the scoreboard with one accepted transaction
  task automatic normalize_item(input in_item_t it);
    logic [DATA_W:0] rc;
    longint          acc;
    int unsigned     lim_slots;
    int unsigned     lim_reps;
    out_item_t       res;
    if (it.operation == OP_LOAD) begin
      rc = round_clip(longint'($signed(it.recip_sqrt_var_value)) *
                      longint'($signed(it.gamma_value)));
      mean_mem[it.param_index]  = it.mean_value;
      scale_mem[it.param_index] = rc[DATA_W-1:0];
      beta_mem[it.param_index]  = it.beta_value;
    end else begin
      if (it.restart) begin
        rep_pos  = '0;
        slot_pos = '0;
      end
      lim_slots = (slots_reg == 0) ? 1 : (slots_reg > NUM_SLOTS) ? NUM_SLOTS : slots_reg;
      lim_reps  = (reps_reg == 0) ? 1 : (reps_reg > (1 << REP_CNT_W)) ? (1 << REP_CNT_W)
                                                                      : reps_reg;
      acc = (longint'($signed(it.sample)) - longint'(mean_mem[slot_pos])) *
            longint'(scale_mem[slot_pos]) +
            (longint'(beta_mem[slot_pos]) <<< FRAC_BITS);
      rc = round_clip(acc);
      res.result_value = rc[DATA_W-1:0];
      res.saturated    = rc[DATA_W];
      res.slot_used    = slot_pos;
      expected_results.push_back(res);
      rep_pos = rep_pos + 1'b1;
      if (rep_pos == 0 || rep_pos >= lim_reps) begin
        rep_pos  = '0;
        slot_pos = slot_pos + 1'b1;
        if (slot_pos == 0 || slot_pos >= lim_slots) slot_pos = '0;
      end
    end
  endtask

  // driver: present queued transactions, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) normalize_item(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch($sformatf("result_value got %h want %h",
                                      out_data.result_value, want.result_value));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      out_data.saturated, want.saturated));
          if (out_data.slot_used !== want.slot_used)
            report_mismatch($sformatf("slot_used got %0d want %0d",
                                      out_data.slot_used, want.slot_used));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return DATA_W'($urandom_range(511)) ^ {DATA_W{1'($urandom_range(1))}};
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic push_load(input logic [SLOT_W-1:0] idx, input logic [DATA_W-1:0] m,
                           input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] g,
                           input logic [DATA_W-1:0] b, input logic rst);
    in_item_t it;
    it = '0;
    it.operation            = OP_LOAD;
    it.param_index          = idx;
    it.mean_value           = m;
    it.recip_sqrt_var_value = r;
    it.gamma_value          = g;
    it.beta_value           = b;
    it.sample               = rand_q();
    it.restart              = rst;
    pending_items.push_back(it);
  endtask

  task automatic push_sample(input logic [DATA_W-1:0] x, input logic rst);
    in_item_t it;
    it = '0;
    it.operation            = OP_SAMPLE;
    it.param_index          = SLOT_W'($urandom);
    it.mean_value           = rand_q();
    it.recip_sqrt_var_value = rand_q();
    it.gamma_value          = rand_q();
    it.beta_value           = rand_q();
    it.sample               = x;
    it.restart              = rst;
    pending_items.push_back(it);
  endtask

  // wait for the pipe to empty, then let any trailing load settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PARAMS_IN_USE) slots_reg = val[PIU_W-1:0];
    else                          reps_reg  = val[REP_W-1:0];
    @(negedge clk);
  endtask

  // mostly well-formed tensors with random content, some reloads and stray restarts
  task automatic run_phase(input logic [CFG_W-1:0] slots, input logic [CFG_W-1:0] reps,
                           input int count, input bit quiet);
    int unsigned tensor_len;
    int          since_restart;
    logic        rst;
    wait_idle();
    write_reg(CFG_PARAMS_IN_USE, slots);
    write_reg(CFG_REPEAT_COUNT, reps);
    idle_pct      = quiet ? 0 : IDLE_PCT;
    tensor_len    = ((slots == 0) ? 1 : slots) * ((reps == 0) ? 1 : reps);
    since_restart = 0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 12) begin
        push_load(SLOT_W'($urandom), rand_q(), rand_q(), rand_q(), rand_q(),
                  1'($urandom_range(1)));
      end else begin
        rst = (since_restart >= tensor_len && $urandom_range(1)) || $urandom_range(99) < 3;
        if (rst) since_restart = 0;
        push_sample(rand_q(), rst);
        since_restart++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill every slot so no sample ever reads an unwritten entry
    write_reg(CFG_PARAMS_IN_USE, 21'd4);
    write_reg(CFG_REPEAT_COUNT, 21'd1);
    for (int s = 0; s < NUM_SLOTS; s++)
      push_load(SLOT_W'(s), rand_q(), rand_q(), rand_q(), rand_q(), 1'($urandom_range(1)));
    wait_idle();

    // extremes, scale clipping both ways, rounding at the half, restart on a load
    push_load(8'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    push_load(8'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
    push_load(8'd2, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 1'b0);
    push_load(8'd3, 16'h0001, 16'hffff, 16'h0081, 16'h0080, 1'b0);
    push_sample(16'h7fff, 1'b1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7fff, 1'b0);
    // reload a slot right before its sample
    push_load(8'd2, 16'h0080, 16'h0080, 16'h0080, 16'h0001, 1'b1);
    push_sample(16'h0100, 1'b0);
    push_load(8'd3, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    push_sample(16'hff80, 1'b0);
    push_sample(16'h0080, 1'b1);
    push_sample(16'hffff, 1'b1);
    push_sample(16'h0001, 1'b0);

    // slot counter past a lowered slot count
    wait_idle();
    write_reg(CFG_PARAMS_IN_USE, 21'd8);
    push_sample(16'h1234, 1'b1);
    repeat (5) push_sample(rand_q(), 1'b0);
    wait_idle();
    write_reg(CFG_PARAMS_IN_USE, 21'd3);
    repeat (3) push_sample(rand_q(), 1'b0);

    // repeat counter past a lowered repeat count
    wait_idle();
    write_reg(CFG_REPEAT_COUNT, 21'd10);
    push_sample(16'h4321, 1'b1);
    repeat (5) push_sample(rand_q(), 1'b0);
    wait_idle();
    write_reg(CFG_REPEAT_COUNT, 21'd3);
    repeat (3) push_sample(rand_q(), 1'b0);

    run_phase(21'd4,       21'd1,       100, 1'b0);
    run_phase(21'd3,       21'd5,       100, 1'b0);
    run_phase(21'd256,     21'd1,       150, 1'b1);
    run_phase(21'd0,       21'd0,        60, 1'b0);
    run_phase(21'd511,     21'd3,        60, 1'b0);
    run_phase(21'd2,       21'd2097151,  40, 1'b0);
    run_phase(21'd1,       21'd1048576,  30, 1'b0);
    run_phase(21'd8,       21'd2,        60, 1'b0);
    run_phase(21'd3,       21'd1,        60, 1'b0);
    run_phase(21'd2,       21'd7,        40, 1'b0);
    run_phase(21'd2,       21'd2,        40, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("** batch_norm_inference: PASSED **");
    end else begin
      $display("** batch_norm_inference: FAILED **");
    end
    $finish;
  end

  // abort a hung run
  initial begin
    #10_000_000;
    $display("** batch_norm_inference: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hdl/bni_pkg.sv
hdl/bni_ctrl.sv
hdl/bni_param_store.sv
hdl/bni_datapath.sv
hdl/batch_norm_inference.sv
hdl/bni_checker.sv
tb/tb_top.sv
